// ===== hdl/hpd_pkg.sv =====
package hpd_pkg;

  localparam int unsigned SYM_BITS      = 8;
  localparam int unsigned DIM_BITS      = 12;
  localparam int unsigned REG_BITS      = DIM_BITS + 1;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned MAX_NODES_DEF = 256;
  localparam int unsigned SYM_COUNT     = 1 << SYM_BITS;
  localparam int unsigned CFG_IDX_BITS  = 1;

  localparam logic [REG_BITS-1:0] DIM_MAX   = REG_BITS'(1 << DIM_BITS);
  localparam logic [REG_BITS-1:0] DIM_RESET = REG_BITS'(256);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // input item kinds
  localparam logic KIND_MERGE = 1'b0;
  localparam logic KIND_CODE  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic                new_tree;
    logic [SYM_BITS-1:0] first_symbol;
    logic [SYM_BITS-1:0] second_symbol;
    logic [7:0]          code_byte;
    logic                end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] pixel_value;
    logic [DIM_BITS-1:0] pixel_row;
    logic [DIM_BITS-1:0] pixel_column;
    logic                last_of_byte;
    logic                image_done;
  } out_item_t;

endpackage

// ===== hdl/hpd_stream_if.sv =====
interface hpd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/huffman_tree_pixel_decoder.sv =====
// huffman tree pixel decoder
// in_item (valid/ready) carries two kinds of item. a merge pair (kind 0) builds the
// code tree: a new_tree pair sets the root's two leaves, every later pair expands
// the leaf of first_symbol into an internal node. a coded byte (kind 1) is walked
// msb first through the tree, one bit per cycle while out_item keeps up; each leaf
// reached gives one pixel item on out_item with its row and column.
// cfg_wr_en/cfg_index/cfg_wdata write image_width (index 0) and image_height
// (index 1); write them only while the block is idle.
// steps: a new_tree pair writes the root's two leaves in turn; any other pair looks
// up its leaf, checks it, then grows a node with two leaves under it. a coded
// byte is accepted, then takes one setup read, its bits and a closing step. the
// rate is set by the child table read: each bit needs the node picked by the
// previous bit, one registered memory read per bit. a pixel is held one stage
// until the next leaf or the end of the byte shows whether it is the byte's last,
// then passes through the output register to out_item.
// if out_item stalls, the walk pauses on a leaf until the held pixel can move on;
// a new item is still accepted while the last pixel waits in the output register.
// reset: walk at the root, row, column and image state cleared, next free node 1,
// width and height 256; the tree contents are undefined until built.
module huffman_tree_pixel_decoder
  import hpd_pkg::*;
#(
  parameter int unsigned MAX_INTERNAL_NODES = MAX_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_wdata,
  hpd_stream_if.sink              in_item,
  hpd_stream_if.source            out_item
);

  localparam int unsigned NB  = $clog2(MAX_INTERNAL_NODES);
  localparam int unsigned CAW = NB + 1;                 // node and side
  localparam int unsigned VW  = (SYM_BITS > NB) ? SYM_BITS : NB;
  localparam int unsigned EW  = VW + 1;                 // leaf flag and value
  localparam int unsigned BCW = $clog2(BYTE_BITS);
  localparam logic [NB:0] MAX_N = (NB + 1)'(MAX_INTERNAL_NODES);
  localparam logic [BCW-1:0] LAST_BIT = BCW'(BYTE_BITS - 1);

  // controller states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FRESH0 = 4'd1;
  localparam logic [3:0] S_FRESH1 = 4'd2;
  localparam logic [3:0] S_LOOK   = 4'd3;
  localparam logic [3:0] S_CHK1   = 4'd4;
  localparam logic [3:0] S_CHK2   = 4'd5;
  localparam logic [3:0] S_GROW0  = 4'd6;
  localparam logic [3:0] S_GROW1  = 4'd7;
  localparam logic [3:0] S_DEC    = 4'd8;
  localparam logic [3:0] S_END    = 4'd9;

  // tree storage
  logic [EW-1:0]  child_mem_r [0:2*MAX_INTERNAL_NODES-1];
  logic [CAW-1:0] lp_mem_r    [0:SYM_COUNT-1];
  logic [EW-1:0]  child_q_r;
  logic [CAW-1:0] lp_q_r;
  logic           cm_we;
  logic [CAW-1:0] cm_waddr, cm_raddr;
  logic [EW-1:0]  cm_wdata;
  logic           lp_we;
  logic [SYM_BITS-1:0] lp_waddr;
  logic [CAW-1:0] lp_wdata;

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [NB:0]         nf_r, nf_nxt;
  logic [NB-1:0]       walk_r, walk_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt, col_r, col_nxt;
  logic                fin_r, fin_nxt;
  logic [REG_BITS-1:0] width_r, height_r;
  logic                pend_r, pend_nxt;
  logic [BCW-1:0]      bcnt_r, bcnt_nxt;
  logic                hold_vld_r, hold_vld_nxt;
  logic                out_vld_r, out_vld_nxt;

  // payload
  logic [SYM_BITS-1:0]  f_r, s_r;
  logic [BYTE_BITS-1:0] sh_r, sh_nxt;
  logic                 eos_r;
  logic [CAW-1:0]       place_r, place_nxt;
  out_item_t            hold_r, hold_nxt, out_r, out_nxt;

  logic                 in_acc, out_free;
  logic                 e_leaf;
  logic [NB-1:0]        e_node;
  logic [REG_BITS-1:0]  w_lim, h_lim, col_inc, row_inc;
  logic                 col_wrap, row_wrap;
  logic [NB-1:0]        nf_lo;

  assign in_item.ready  = (state_r == S_IDLE);
  assign in_acc         = in_item.valid && in_item.ready;
  assign out_item.valid = out_vld_r;
  assign out_item.data  = out_r;
  assign out_free       = !out_vld_r || out_item.ready;

  assign e_leaf = child_q_r[EW-1];
  assign e_node = child_q_r[NB-1:0];
  assign nf_lo  = nf_r[NB-1:0];

  // zero counts as 1, anything above the largest image as the largest
  assign w_lim = (width_r == '0) ? REG_BITS'(1) : ((width_r > DIM_MAX) ? DIM_MAX : width_r);
  assign h_lim = (height_r == '0) ? REG_BITS'(1) :
                 ((height_r > DIM_MAX) ? DIM_MAX : height_r);
  assign col_inc  = {1'b0, col_r} + REG_BITS'(1);
  assign row_inc  = {1'b0, row_r} + REG_BITS'(1);
  assign col_wrap = (col_inc >= w_lim);
  assign row_wrap = (row_inc >= h_lim);

  // child table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cm_we) begin
      child_mem_r[cm_waddr] <= cm_wdata;
    end
    child_q_r <= child_mem_r[cm_raddr];
  end

  // leaf place table: symbol to node and side of its leaf
  always_ff @(posedge clk) begin
    if (lp_we) begin
      lp_mem_r[lp_waddr] <= lp_wdata;
    end
    lp_q_r <= lp_mem_r[f_r];
  end

  always_comb begin
    state_nxt    = state_r;
    nf_nxt       = nf_r;
    walk_nxt     = walk_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fin_nxt      = fin_r;
    pend_nxt     = pend_r;
    bcnt_nxt     = bcnt_r;
    sh_nxt       = sh_r;
    place_nxt    = place_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    out_vld_nxt  = out_vld_r && !out_item.ready;
    out_nxt      = out_r;
    cm_we        = 1'b0;
    cm_waddr     = '0;
    cm_wdata     = '0;
    cm_raddr     = {walk_r, sh_r[BYTE_BITS-1]};
    lp_we        = 1'b0;
    lp_waddr     = f_r;
    lp_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sh_nxt = in_item.data.code_byte;
          if (in_item.data.kind == KIND_MERGE) begin
            state_nxt = in_item.data.new_tree ? S_FRESH0 : S_LOOK;
          end else begin
            pend_nxt  = 1'b0;
            bcnt_nxt  = '0;
            state_nxt = fin_r ? S_END : S_DEC;
          end
        end
      end

      // new tree: both leaves hang off the root
      S_FRESH0: begin
        cm_we     = 1'b1;
        cm_waddr  = {NB'(0), 1'b0};
        cm_wdata  = {1'b1, VW'(f_r)};
        lp_we     = 1'b1;
        lp_waddr  = f_r;
        lp_wdata  = {NB'(0), 1'b0};
        state_nxt = S_FRESH1;
      end
      S_FRESH1: begin
        cm_we     = 1'b1;
        cm_waddr  = {NB'(0), 1'b1};
        cm_wdata  = {1'b1, VW'(s_r)};
        lp_we     = 1'b1;
        lp_waddr  = s_r;
        lp_wdata  = {NB'(0), 1'b1};
        nf_nxt    = (NB + 1)'(1);
        walk_nxt  = '0;
        state_nxt = S_IDLE;
      end

      // expand a leaf: find it, check it, then grow a node under it
      S_LOOK: begin
        state_nxt = S_CHK1;
      end
      S_CHK1: begin
        if (nf_r >= MAX_N || {1'b0, lp_q_r[CAW-1:1]} >= nf_r) begin
          state_nxt = S_IDLE;
        end else begin
          cm_raddr  = lp_q_r;
          place_nxt = lp_q_r;
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        if (child_q_r == {1'b1, VW'(f_r)}) begin
          cm_we     = 1'b1;
          cm_waddr  = place_r;
          cm_wdata  = {1'b0, VW'(nf_lo)};
          state_nxt = S_GROW0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GROW0: begin
        cm_we     = 1'b1;
        cm_waddr  = {nf_lo, 1'b0};
        cm_wdata  = {1'b1, VW'(f_r)};
        lp_we     = 1'b1;
        lp_waddr  = f_r;
        lp_wdata  = {nf_lo, 1'b0};
        state_nxt = S_GROW1;
      end
      S_GROW1: begin
        cm_we     = 1'b1;
        cm_waddr  = {nf_lo, 1'b1};
        cm_wdata  = {1'b1, VW'(s_r)};
        lp_we     = 1'b1;
        lp_waddr  = s_r;
        lp_wdata  = {nf_lo, 1'b1};
        nf_nxt    = nf_r + (NB + 1)'(1);
        state_nxt = S_IDLE;
      end

      // bit walk: child_q_r holds the entry for the bit at the top of sh_r
      S_DEC: begin
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else if (!e_leaf || !hold_vld_r || out_free) begin
          if (e_leaf) begin
            // previous pixel is not the byte's last: pass it on
            if (hold_vld_r) begin
              out_nxt              = hold_r;
              out_nxt.last_of_byte = 1'b0;
              out_vld_nxt          = 1'b1;
            end
            hold_vld_nxt          = 1'b1;
            hold_nxt.pixel_value  = child_q_r[SYM_BITS-1:0];
            hold_nxt.pixel_row    = row_r;
            hold_nxt.pixel_column = col_r;
            hold_nxt.last_of_byte = 1'b1;
            hold_nxt.image_done   = col_wrap && row_wrap;
            walk_nxt              = '0;
            if (col_wrap) begin
              col_nxt = '0;
              if (row_wrap) begin
                row_nxt = '0;
                fin_nxt = 1'b1;
              end else begin
                row_nxt = row_inc[DIM_BITS-1:0];
              end
            end else begin
              col_nxt = col_inc[DIM_BITS-1:0];
            end
          end else begin
            walk_nxt = e_node;
          end
          sh_nxt = sh_r << 1;
          if (bcnt_r == LAST_BIT || (e_leaf && col_wrap && row_wrap)) begin
            // byte used up or image complete: rest of the bits are dropped
            pend_nxt  = 1'b0;
            state_nxt = S_END;
          end else begin
            bcnt_nxt = bcnt_r + BCW'(1);
            cm_raddr = {walk_nxt, sh_r[BYTE_BITS-2]};
          end
        end
      end

      // flush the held pixel as the byte's last, then end of stream
      S_END: begin
        if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_nxt      = hold_r;
            out_vld_nxt  = 1'b1;
            hold_vld_nxt = 1'b0;
          end
          if (eos_r) begin
            walk_nxt = '0;
            row_nxt  = '0;
            col_nxt  = '0;
            fin_nxt  = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      nf_r       <= (NB + 1)'(1);
      walk_r     <= '0;
      row_r      <= '0;
      col_r      <= '0;
      fin_r      <= 1'b0;
      pend_r     <= 1'b0;
      bcnt_r     <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      width_r    <= DIM_RESET;
      height_r   <= DIM_RESET;
    end else begin
      state_r    <= state_nxt;
      nf_r       <= nf_nxt;
      walk_r     <= walk_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fin_r      <= fin_nxt;
      pend_r     <= pend_nxt;
      bcnt_r     <= bcnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_r   <= in_item.data.first_symbol;
      s_r   <= in_item.data.second_symbol;
      eos_r <= in_item.data.end_of_stream;
    end
    sh_r    <= sh_nxt;
    place_r <= place_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  // a finished image always leaves the position at the origin
  a_fin_origin: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (row_r == '0 && col_r == '0))
    else $error("finished image with nonzero position");

  // a held pixel never outlives its byte
  a_hold_scope: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (state_r == S_DEC || state_r == S_END))
    else $error("held pixel outside a coded byte");

  // node allocator stays within the table
  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nf_r != '0 && nf_r <= MAX_N))
    else $error("next free node out of range");

  // the pixel that completes the image is the last of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.image_done) |-> out_r.last_of_byte)
    else $error("image done on a pixel that is not last of byte");

endmodule
